// ===== rtl/rebq_pkg.sv =====
// Shared constants for the rotary encoder and push-button qualifier.
// No dependencies; every other file in rtl/ refers to this package by scoped names.
package rebq_pkg;

    localparam int unsigned CfgIndexBits = 1;
    localparam int unsigned CfgDataBits  = 16;
    localparam int unsigned TimeBits     = 32;
    localparam int unsigned CountOutBits = 32;
    localparam int unsigned DeltaBits    = 8;

    // Configuration register indexes.
    localparam logic [CfgIndexBits-1:0] CFG_DEBOUNCE   = 1'd0;
    localparam logic [CfgIndexBits-1:0] CFG_LONG_PRESS = 1'd1;

    // Reset values of the configuration registers.
    localparam logic [CfgDataBits-1:0] DEBOUNCE_RESET   = 16'd50;
    localparam logic [CfgDataBits-1:0] LONG_PRESS_RESET = 16'd1000;

    // Saturation limits of the reported delta.
    localparam logic signed [DeltaBits-1:0] DELTA_MAX = 8'sd127;
    localparam logic signed [DeltaBits-1:0] DELTA_MIN = -8'sd128;

    typedef logic [TimeBits-1:0] time_ms_t;

endpackage

// ===== rtl/rebq_in_if.sv =====
// Sample channel of the encoder qualifier: valid/ready plus one pin sample.
// Depends on rebq_pkg.
interface rebq_in_if;
    logic                      valid;
    logic                      ready;
    logic                      clk_level;
    logic                      dt_level;
    logic                      sw_level;
    rebq_pkg::time_ms_t        now_ms;
    logic                      take_delta;
    logic                      take_click;
    logic                      take_long;

    modport source (output valid, clk_level, dt_level, sw_level, now_ms,
                    take_delta, take_click, take_long, input ready);
    modport sink   (input valid, clk_level, dt_level, sw_level, now_ms,
                    take_delta, take_click, take_long, output ready);
endinterface

// ===== rtl/rebq_out_if.sv =====
// Result channel of the encoder qualifier: valid/ready plus one status beat.
// Depends on rebq_pkg.
interface rebq_out_if;
    logic                                          valid;
    logic                                          ready;
    logic signed [rebq_pkg::DeltaBits-1:0]         delta;
    logic                                          clicked;
    logic                                          long_pressed;
    logic                                          held;
    logic signed [rebq_pkg::CountOutBits-1:0]      count;

    modport source (output valid, delta, clicked, long_pressed, held, count,
                    input ready);
    modport sink   (input valid, delta, clicked, long_pressed, held, count,
                    output ready);
endinterface

// ===== rtl/rotary_encoder_button_qualifier_core.sv =====
// Rotary encoder position counter and push-button qualifier, top level.
// Depends on rebq_pkg, rebq_in_if and rebq_out_if.
//
// Usage:
//   sample : one beat per pin sample (encoder clock, data, switch levels, a
//            millisecond timestamp and three read-and-clear requests).
//   result : one beat per sample beat: saturated delta, click and long-press
//            flags (only when requested), debounced switch state and position.
//   cfg    : write debounce_ms (index 0) and long_press_ms (index 1) while idle.
// Path: a sample beat lands in the input register at the accepting edge;
//   its result is then registered in the output register, which offers
//   the result beat to the receiver.
// Throughput: one beat per cycle while result.ready stays high. All of the
//   update (edge detect, position step, debounce and hold-time compares, delta
//   saturation) is a single pass of logic between the input and output registers.
// Stall: while the receiver holds ready low, the output register keeps its
//   beat, the input register keeps one more, and then sample.ready drops.
//   Encoder and switch state only advance when a beat moves to the output.
// Reset: both pipeline registers empty, position and reference zero, flags
//   clear, previous clock line high, timers zero, configuration at 50/1000 ms.
module rotary_encoder_button_qualifier_core #(
    parameter int unsigned COUNT_BITS = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    rebq_in_if.sink                              sample,
    rebq_out_if.source                           result,
    input  logic                                 cfg_we,
    input  logic [rebq_pkg::CfgIndexBits-1:0]    cfg_index,
    input  logic [rebq_pkg::CfgDataBits-1:0]     cfg_data
);

    localparam logic signed [COUNT_BITS-1:0] CNT_MAX = COUNT_BITS'(127);
    localparam logic signed [COUNT_BITS-1:0] CNT_MIN = ~CNT_MAX;

    // Configuration registers.
    logic [rebq_pkg::CfgDataBits-1:0] debounce_reg;
    logic [rebq_pkg::CfgDataBits-1:0] long_press_reg;

    // Input register (one sample beat).
    logic               s1_valid_reg;
    logic               s1_clk_reg;
    logic               s1_dt_reg;
    logic               s1_sw_reg;
    rebq_pkg::time_ms_t s1_now_reg;
    logic               s1_take_delta_reg;
    logic               s1_take_click_reg;
    logic               s1_take_long_reg;

    // Qualifier state.
    logic                    prev_clk_reg;
    logic [COUNT_BITS-1:0]   position_reg;
    logic [COUNT_BITS-1:0]   reference_reg;
    logic                    pressed_reg;
    logic                    click_reg;
    logic                    long_reg;
    rebq_pkg::time_ms_t      last_change_reg;
    rebq_pkg::time_ms_t      press_start_reg;

    // Output register.
    logic                                        out_valid_reg;
    logic signed [rebq_pkg::DeltaBits-1:0]       out_delta_reg;
    logic                                        out_clicked_reg;
    logic                                        out_long_reg;
    logic                                        out_held_reg;
    logic [rebq_pkg::CountOutBits-1:0]           out_count_reg;

    // Next values.
    logic                                        advance;
    logic                                        clk_fall;
    logic [COUNT_BITS-1:0]                       position_next;
    logic [COUNT_BITS-1:0]                       reference_next;
    logic signed [COUNT_BITS-1:0]                diff;
    logic signed [rebq_pkg::DeltaBits-1:0]       delta_next;
    rebq_pkg::time_ms_t                          since_change;
    rebq_pkg::time_ms_t                          held_time;
    rebq_pkg::time_ms_t                          hold_now;
    logic                                        debounce_ok;
    logic                                        press_go;
    logic                                        release_go;
    logic                                        long_at_release;
    logic                                        pressed_next;
    rebq_pkg::time_ms_t                          press_start_next;
    rebq_pkg::time_ms_t                          last_change_next;
    logic                                        click_seen;
    logic                                        long_seen;
    logic                                        click_next;
    logic                                        long_next;
    logic [63:0]                                 position_wide;
    logic [63:0]                                 position_now_wide;

    // Move the input beat on whenever the output register is free or drains.
    assign advance      = s1_valid_reg && (!out_valid_reg || result.ready);
    assign sample.ready = !s1_valid_reg || advance;

    // Falling edge of the encoder clock steps the position by the data line.
    assign clk_fall = prev_clk_reg && !s1_clk_reg;

    always_comb
    begin
        position_next = position_reg;
        if (clk_fall)
        begin
            position_next = s1_dt_reg ? position_reg + COUNT_BITS'(1)
                                      : position_reg - COUNT_BITS'(1);
        end
    end

    // Switch debounce: a change needs strictly more than debounce_ms since the last one.
    assign since_change    = s1_now_reg - last_change_reg;
    assign held_time       = s1_now_reg - press_start_reg;
    assign debounce_ok     = since_change > rebq_pkg::TimeBits'(debounce_reg);
    assign press_go        = !s1_sw_reg && !pressed_reg && debounce_ok;
    assign release_go      = s1_sw_reg && pressed_reg && debounce_ok;
    assign long_at_release = held_time >= rebq_pkg::TimeBits'(long_press_reg);

    assign pressed_next     = press_go || (pressed_reg && !release_go);
    assign press_start_next = press_go ? s1_now_reg : press_start_reg;
    assign last_change_next = (press_go || release_go) ? s1_now_reg : last_change_reg;

    // Hold time after this sample; zero when the press starts on it.
    assign hold_now = press_go ? '0 : held_time;

    assign click_seen = click_reg || (release_go && !long_at_release);
    assign long_seen  = long_reg || (release_go && long_at_release)
                     || (pressed_next && hold_now >= rebq_pkg::TimeBits'(long_press_reg));

    assign click_next = s1_take_click_reg ? 1'b0 : click_seen;
    assign long_next  = s1_take_long_reg ? 1'b0 : long_seen;

    // Delta since the last read, wrapped to the counter width then saturated.
    assign diff = position_next - reference_reg;

    always_comb
    begin
        delta_next = '0;
        if (s1_take_delta_reg)
        begin
            if (diff > CNT_MAX)
            begin
                delta_next = rebq_pkg::DELTA_MAX;
            end
            else if (diff < CNT_MIN)
            begin
                delta_next = rebq_pkg::DELTA_MIN;
            end
            else
            begin
                delta_next = diff[rebq_pkg::DeltaBits-1:0];
            end
        end
    end

    assign reference_next    = s1_take_delta_reg ? position_next : reference_reg;
    assign position_wide     = 64'(position_next);
    assign position_now_wide = 64'(position_reg);

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg   <= rebq_pkg::DEBOUNCE_RESET;
            long_press_reg <= rebq_pkg::LONG_PRESS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                rebq_pkg::CFG_DEBOUNCE:   debounce_reg   <= cfg_data;
                rebq_pkg::CFG_LONG_PRESS: long_press_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Input register: valid bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (sample.ready)
        begin
            s1_valid_reg <= sample.valid;
        end
    end

    // Input register: payload, loaded on each accepted sample beat.
    always_ff @(posedge clk)
    begin
        if (sample.valid && sample.ready)
        begin
            s1_clk_reg        <= sample.clk_level;
            s1_dt_reg         <= sample.dt_level;
            s1_sw_reg         <= sample.sw_level;
            s1_now_reg        <= sample.now_ms;
            s1_take_delta_reg <= sample.take_delta;
            s1_take_click_reg <= sample.take_click;
            s1_take_long_reg  <= sample.take_long;
        end
    end

    // Qualifier state advances with each beat that moves to the output.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_clk_reg    <= 1'b1;
            position_reg    <= '0;
            reference_reg   <= '0;
            pressed_reg     <= 1'b0;
            click_reg       <= 1'b0;
            long_reg        <= 1'b0;
            last_change_reg <= '0;
            press_start_reg <= '0;
        end
        else if (advance)
        begin
            prev_clk_reg    <= s1_clk_reg;
            position_reg    <= position_next;
            reference_reg   <= reference_next;
            pressed_reg     <= pressed_next;
            click_reg       <= click_next;
            long_reg        <= long_next;
            last_change_reg <= last_change_next;
            press_start_reg <= press_start_next;
        end
    end

    // Output register: valid bit; hold the beat until it is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register: payload.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_delta_reg   <= delta_next;
            out_clicked_reg <= s1_take_click_reg && click_seen;
            out_long_reg    <= s1_take_long_reg && long_seen;
            out_held_reg    <= pressed_next;
            out_count_reg   <= position_wide[rebq_pkg::CountOutBits-1:0];
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.delta        = out_delta_reg;
    assign result.clicked      = out_clicked_reg;
    assign result.long_pressed = out_long_reg;
    assign result.held         = out_held_reg;
    assign result.count        = signed'(out_count_reg);

    // State only moves with a beat, so a waiting result matches the live state.
    a_held_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_held_reg == pressed_reg)
        else $error("held output disagrees with debounced switch state");

    a_count_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_count_reg == position_now_wide[rebq_pkg::CountOutBits-1:0])
        else $error("count output disagrees with position");

    a_state_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(position_reg) && $stable(pressed_reg)
                     && $stable(reference_reg))
        else $error("qualifier state moved without a beat");

    a_press_stamps: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(pressed_reg) |-> press_start_reg == last_change_reg)
        else $error("press start and last change disagree on a new press");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (sample.valid && sample.ready && s1_valid_reg) |-> advance)
        else $error("sample beat accepted over a waiting input beat");

endmodule

// ===== tb/tb_rotary_encoder_button_qualifier_core.sv =====
// Self-checking testbench for the rotary encoder and push-button qualifier core.
// Drives pin samples and checks every status beat against an in-bench predictor.
// Depends on rebq_pkg, rebq_in_if, rebq_out_if and rotary_encoder_button_qualifier_core.
`timescale 1ns / 100ps

module tb_rotary_encoder_button_qualifier_core;

    localparam int unsigned COUNT_BITS = 32;

    // One pin sample as the sender presents it.
    typedef struct packed {
        logic               clk_level;
        logic               dt_level;
        logic               sw_level;
        rebq_pkg::time_ms_t now_ms;
        logic               take_delta;
        logic               take_click;
        logic               take_long;
    } sample_t;

    // One status beat as the receiver sees it.
    typedef struct packed {
        logic [rebq_pkg::DeltaBits-1:0]    delta;
        logic                              clicked;
        logic                              long_pressed;
        logic                              held;
        logic [rebq_pkg::CountOutBits-1:0] count;
    } status_t;

    logic                              clk;
    logic                              rst_n;
    logic                              cfg_we;
    logic [rebq_pkg::CfgIndexBits-1:0] cfg_index;
    logic [rebq_pkg::CfgDataBits-1:0]  cfg_data;

    rebq_in_if  sample ();
    rebq_out_if result ();

    rotary_encoder_button_qualifier_core #(
        .COUNT_BITS(COUNT_BITS)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (sample),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Samples waiting for the driver, and status beats the block still owes us.
    sample_t pending_samples[$];
    status_t expected_status[$];

    // Shadow of the configuration registers.
    logic [rebq_pkg::CfgDataBits-1:0] cfg_debounce;
    logic [rebq_pkg::CfgDataBits-1:0] cfg_long_press;

    // Predicted encoder and switch state.
    logic                  enc_prev_clk;
    logic [COUNT_BITS-1:0] enc_position;
    logic [COUNT_BITS-1:0] enc_reference;
    logic                  btn_pressed;
    logic                  btn_click;
    logic                  btn_long;
    rebq_pkg::time_ms_t    btn_last_change;
    rebq_pkg::time_ms_t    btn_press_start;

    // Stimulus generator state: the pin levels and clock it is currently "at".
    rebq_pkg::time_ms_t gen_now;
    logic               gen_clk;
    logic               gen_sw;
    int                 gen_count;

    bit idle_enable;
    int mismatch_count;
    int beats_checked;
    int clicks_read;
    int longs_read;
    int clamped_reads;

    //------------------------------------------------------------------------
    // Clock and the one reset at the start of the run.
    //------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Hard stop in case the block hangs a handshake.
    initial
    begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    //------------------------------------------------------------------------
    // Predictor: apply one sample to the shadow state and return the status
    // beat it must produce. The sample lands first (rotation, switch, long
    // press while held), then the reads are taken, so a read sees events
    // caused by the very same sample.
    //------------------------------------------------------------------------
    function automatic status_t qualify_sample(input sample_t s);
        status_t               st;
        rebq_pkg::time_ms_t    since_change;
        rebq_pkg::time_ms_t    since_press;
        logic [COUNT_BITS-1:0] moved;

        // Falling edge of the encoder clock steps the position by the data line.
        if (!s.clk_level && enc_prev_clk)
            enc_position = s.dt_level ? enc_position + 1'b1 : enc_position - 1'b1;
        enc_prev_clk = s.clk_level;

        // Debounce by time: a change is taken only once strictly more than
        // debounce_ms have passed since the last accepted change (mod 2^32).
        since_change = s.now_ms - btn_last_change;
        if (!s.sw_level && !btn_pressed)
        begin
            if (since_change > rebq_pkg::time_ms_t'(cfg_debounce))
            begin
                btn_pressed     = 1'b1;
                btn_press_start = s.now_ms;
                btn_last_change = s.now_ms;
            end
        end
        else if (s.sw_level && btn_pressed)
        begin
            if (since_change > rebq_pkg::time_ms_t'(cfg_debounce))
            begin
                btn_pressed     = 1'b0;
                btn_last_change = s.now_ms;
                since_press     = s.now_ms - btn_press_start;
                if (since_press >= rebq_pkg::time_ms_t'(cfg_long_press))
                    btn_long = 1'b1;
                else
                    btn_click = 1'b1;
            end
        end

        // Long press is flagged while still held; after a read it comes back
        // on the next sample as long as the switch stays down.
        since_press = s.now_ms - btn_press_start;
        if (btn_pressed && !btn_long && since_press >= rebq_pkg::time_ms_t'(cfg_long_press))
            btn_long = 1'b1;

        st = '0;
        if (s.take_delta)
        begin
            // Difference wraps at the counter width, then clamps to 8 bits.
            moved = enc_position - enc_reference;
            if ($signed(moved) > rebq_pkg::DELTA_MAX)
                st.delta = rebq_pkg::DELTA_MAX;
            else if ($signed(moved) < rebq_pkg::DELTA_MIN)
                st.delta = rebq_pkg::DELTA_MIN;
            else
                st.delta = moved[rebq_pkg::DeltaBits-1:0];
            if ($signed(moved) > rebq_pkg::DELTA_MAX || $signed(moved) < rebq_pkg::DELTA_MIN)
                clamped_reads++;
            enc_reference = enc_position;
        end
        if (s.take_click)
        begin
            st.clicked = btn_click;
            clicks_read += btn_click;
            btn_click = 1'b0;
        end
        if (s.take_long)
        begin
            st.long_pressed = btn_long;
            longs_read += btn_long;
            btn_long = 1'b0;
        end
        st.held  = btn_pressed;
        st.count = enc_position[rebq_pkg::CountOutBits-1:0];
        return st;
    endfunction

    //------------------------------------------------------------------------
    // Sample driver: hold the beat until it is taken, then present the next
    // pending one or idle at random.
    //------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : sample_driver
        sample_t beat;
        if (!rst_n)
        begin
            sample.valid      <= 1'b0;
            sample.clk_level  <= 1'b1;
            sample.dt_level   <= 1'b0;
            sample.sw_level   <= 1'b1;
            sample.now_ms     <= '0;
            sample.take_delta <= 1'b0;
            sample.take_click <= 1'b0;
            sample.take_long  <= 1'b0;
        end
        else if (!sample.valid || sample.ready)
        begin
            if (pending_samples.size() != 0 &&
                !(idle_enable && $urandom_range(0, 99) < 21))
            begin
                beat = pending_samples.pop_front();
                sample.valid      <= 1'b1;
                sample.clk_level  <= beat.clk_level;
                sample.dt_level   <= beat.dt_level;
                sample.sw_level   <= beat.sw_level;
                sample.now_ms     <= beat.now_ms;
                sample.take_delta <= beat.take_delta;
                sample.take_click <= beat.take_click;
                sample.take_long  <= beat.take_long;
            end
            else
            begin
                sample.valid <= 1'b0;
            end
        end
    end

    //------------------------------------------------------------------------
    // Status monitor: predict on every accepted sample, then check every
    // accepted status beat against the oldest prediction. Stall at random.
    //------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : status_monitor
        sample_t taken;
        status_t want;
        status_t got;
        if (!rst_n)
        begin
            result.ready <= 1'b0;
        end
        else
        begin
            if (sample.valid && sample.ready)
            begin
                taken = {sample.clk_level, sample.dt_level, sample.sw_level, sample.now_ms,
                         sample.take_delta, sample.take_click, sample.take_long};
                expected_status.push_back(qualify_sample(taken));
            end

            if (result.valid && result.ready)
            begin
                got = {result.delta, result.clicked, result.long_pressed, result.held,
                       result.count};
                if (expected_status.size() == 0)
                begin
                    $error("status beat with nothing expected: delta %0d count %0d",
                           $signed(got.delta), $signed(got.count));
                    mismatch_count++;
                end
                else
                begin
                    want = expected_status.pop_front();
                    beats_checked++;
                    if (got.delta !== want.delta)
                    begin
                        $error("delta: expected %0d, got %0d",
                               $signed(want.delta), $signed(got.delta));
                        mismatch_count++;
                    end
                    if (got.clicked !== want.clicked)
                    begin
                        $error("clicked: expected %0b, got %0b", want.clicked, got.clicked);
                        mismatch_count++;
                    end
                    if (got.long_pressed !== want.long_pressed)
                    begin
                        $error("long_pressed: expected %0b, got %0b",
                               want.long_pressed, got.long_pressed);
                        mismatch_count++;
                    end
                    if (got.held !== want.held)
                    begin
                        $error("held: expected %0b, got %0b", want.held, got.held);
                        mismatch_count++;
                    end
                    if (got.count !== want.count)
                    begin
                        $error("count: expected %0d, got %0d",
                               $signed(want.count), $signed(got.count));
                        mismatch_count++;
                    end
                end
            end

            result.ready <= idle_enable ? ($urandom_range(0, 99) >= 21) : 1'b1;
        end
    end

    //------------------------------------------------------------------------
    // Stimulus helpers.
    //------------------------------------------------------------------------

    // Write one register on an idle block and mirror it in the shadow copy.
    task automatic write_cfg(input logic [rebq_pkg::CfgIndexBits-1:0] idx,
                             input logic [rebq_pkg::CfgDataBits-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == rebq_pkg::CFG_DEBOUNCE)
            cfg_debounce = value;
        else
            cfg_long_press = value;
    endtask

    // Wait until every sample is taken and every status beat has arrived.
    task automatic wait_drain();
        do
            @(posedge clk);
        while (pending_samples.size() != 0 || sample.valid || expected_status.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic queue_sample(input rebq_pkg::time_ms_t at, input logic c, input logic d,
                                input logic w, input logic [2:0] takes);
        pending_samples.push_back({c, d, w, at, takes[2], takes[1], takes[0]});
        gen_now = at;
        gen_count++;
    endtask

    // Each read request on about one sample in four: {delta, click, long}.
    function automatic logic [2:0] random_takes();
        return {$urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0,
                $urandom_range(0, 3) == 0};
    endfunction

    // Step time on a scale that lands around the debounce and long-press
    // thresholds, with a rare jump anywhere in the 32-bit range.
    task automatic queue_next(input logic c, input logic d, input logic w,
                              input logic [2:0] takes);
        int unsigned span;
        span = ((cfg_debounce > cfg_long_press ? cfg_debounce : cfg_long_press) >> 2) + 4;
        if ($urandom_range(0, 31) == 0)
            queue_sample(gen_now + $urandom, c, d, w, takes);
        else
            queue_sample(gen_now + $urandom_range(0, span), c, d, w, takes);
        gen_clk = c;
    endtask

    // Clean detents: clock high then low with a steady data line. A quiet
    // burst reads the delta only before and after, so long ones saturate.
    task automatic turn(input int unsigned detents, input logic up, input bit quiet);
        int unsigned i;
        for (i = 0; i < detents; i++)
        begin
            queue_next(1'b1, up, gen_sw, quiet ? (i == 0 ? 3'b100 : 3'b000) : random_takes());
            queue_next(1'b0, up, gen_sw, quiet ? 3'b000 : random_takes());
        end
        if (quiet)
            queue_next(1'b0, 1'($urandom_range(0, 1)), gen_sw, 3'b100);
    endtask

    // Mostly well-formed gestures with random content, some raw noise.
    task automatic add_gestures(input int n);
        int          target;
        int unsigned kind;
        int unsigned i;
        int unsigned hold_len;
        target = gen_count + n;
        while (gen_count < target)
        begin
            kind = $urandom_range(0, 9);
            if (kind <= 3)
            begin
                if ($urandom_range(0, 39) == 0)
                    turn($urandom_range(129, 140), 1'($urandom_range(0, 1)), 1'b1);
                else
                    turn($urandom_range(1, 6), 1'($urandom_range(0, 1)), 1'b0);
            end
            else if (kind <= 6)
            begin
                // Press, hold with the odd bounce, release with the odd bounce.
                hold_len = $urandom_range(1, 6);
                for (i = 0; i < hold_len; i++)
                    queue_next(gen_clk, 1'($urandom_range(0, 1)), $urandom_range(0, 4) == 0,
                               random_takes());
                hold_len = $urandom_range(1, 4);
                for (i = 0; i < hold_len; i++)
                    queue_next(gen_clk, 1'($urandom_range(0, 1)), $urandom_range(0, 4) != 0,
                               random_takes());
                // Now and then stay down so rotation happens while held.
                gen_sw = ($urandom_range(0, 3) != 0);
                queue_next(gen_clk, 1'($urandom_range(0, 1)), gen_sw, random_takes());
            end
            else if (kind == 7)
            begin
                // Noise: any levels, sometimes any time at all.
                gen_clk = 1'($urandom_range(0, 1));
                queue_sample($urandom_range(0, 3) == 0 ? rebq_pkg::time_ms_t'($urandom)
                                                       : gen_now + $urandom_range(0, 8),
                             gen_clk, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                             3'($urandom_range(0, 7)));
            end
            else
            begin
                // Quiet samples that only read.
                queue_next(gen_clk, 1'($urandom_range(0, 1)), gen_sw, random_takes());
            end
        end
    endtask

    //------------------------------------------------------------------------
    // Test sequence.
    //------------------------------------------------------------------------
    initial
    begin
        // Known levels on every input from time zero; reset falls in this step.
        rst_n     = 1'b1;
        cfg_we    = 1'b0;
        cfg_index = rebq_pkg::CFG_DEBOUNCE;
        cfg_data  = '0;
        rst_n     <= 1'b0;

        cfg_debounce    = rebq_pkg::DEBOUNCE_RESET;
        cfg_long_press  = rebq_pkg::LONG_PRESS_RESET;
        enc_prev_clk    = 1'b1;
        enc_position    = '0;
        enc_reference   = '0;
        btn_pressed     = 1'b0;
        btn_click       = 1'b0;
        btn_long        = 1'b0;
        btn_last_change = '0;
        btn_press_start = '0;
        gen_now         = '0;
        gen_clk         = 1'b1;
        gen_sw          = 1'b1;
        gen_count       = 0;
        idle_enable     = 1'b1;
        mismatch_count  = 0;
        beats_checked   = 0;
        clicks_read     = 0;
        longs_read      = 0;
        clamped_reads   = 0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Rewrite the reset values right after reset; directed part runs on
        // the default 50 ms debounce and 1000 ms long press.
        write_cfg(rebq_pkg::CFG_DEBOUNCE, rebq_pkg::DEBOUNCE_RESET);
        write_cfg(rebq_pkg::CFG_LONG_PRESS, rebq_pkg::LONG_PRESS_RESET);

        // Rotation: no edge on a high line, one step up, two steps down,
        // then read a delta of -1 with the position at all ones.
        queue_sample(32'd0, 1'b1, 1'b0, 1'b1, 3'b000);
        queue_sample(32'd1, 1'b0, 1'b1, 1'b1, 3'b000);
        queue_sample(32'd2, 1'b1, 1'b0, 1'b1, 3'b000);
        queue_sample(32'd3, 1'b0, 1'b0, 1'b1, 3'b000);
        queue_sample(32'd4, 1'b1, 1'b0, 1'b1, 3'b000);
        queue_sample(32'd5, 1'b0, 1'b0, 1'b1, 3'b100);
        // Debounce edge: exactly debounce_ms is refused, one more is taken.
        queue_sample(32'd10, 1'b1, 1'b0, 1'b0, 3'b000);
        queue_sample(32'd50, 1'b1, 1'b0, 1'b0, 3'b000);
        queue_sample(32'd51, 1'b1, 1'b0, 1'b0, 3'b000);
        // Early release is refused, later one gives a click read in the same beat.
        queue_sample(32'd100, 1'b1, 1'b0, 1'b1, 3'b000);
        queue_sample(32'd102, 1'b1, 1'b0, 1'b1, 3'b011);
        // Held long press: one short of the limit, at the limit, re-armed
        // after a read, and set again on release.
        queue_sample(32'd200, 1'b1, 1'b0, 1'b0, 3'b000);
        queue_sample(32'd1199, 1'b1, 1'b0, 1'b0, 3'b001);
        queue_sample(32'd1200, 1'b1, 1'b0, 1'b0, 3'b001);
        queue_sample(32'd1201, 1'b1, 1'b0, 1'b0, 3'b001);
        queue_sample(32'd1300, 1'b1, 1'b0, 1'b1, 3'b111);
        // Timestamps wrapping through zero during a press.
        queue_sample(32'hFFFF_FF80, 1'b1, 1'b0, 1'b0, 3'b000);
        queue_sample(32'h0000_0010, 1'b1, 1'b0, 1'b1, 3'b010);
        queue_sample(32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 3'b111);
        queue_sample(32'h0000_0000, 1'b0, 1'b1, 1'b0, 3'b000);
        queue_sample(32'h5555_5555, 1'b1, 1'b0, 1'b0, 3'b111);
        queue_sample(32'hAAAA_AAAA, 1'b0, 1'b1, 1'b1, 3'b111);
        gen_clk = 1'b0;
        wait_drain();

        // Both thresholds at zero: every accepted press is long at once.
        write_cfg(rebq_pkg::CFG_DEBOUNCE, 16'd0);
        write_cfg(rebq_pkg::CFG_LONG_PRESS, 16'd0);
        add_gestures(80);
        wait_drain();

        // Both at the top of their range.
        write_cfg(rebq_pkg::CFG_DEBOUNCE, 16'hFFFF);
        write_cfg(rebq_pkg::CFG_LONG_PRESS, 16'hFFFF);
        add_gestures(80);
        wait_drain();

        // Small thresholds with both sides running flat out.
        write_cfg(rebq_pkg::CFG_DEBOUNCE, 16'd5);
        write_cfg(rebq_pkg::CFG_LONG_PRESS, 16'd40);
        idle_enable = 1'b0;
        turn(135, 1'b1, 1'b1);
        add_gestures(160);
        wait_drain();
        idle_enable = 1'b1;

        // Idling back on; stop the sender mid-phase until the block drains.
        write_cfg(rebq_pkg::CFG_DEBOUNCE, 16'd3);
        write_cfg(rebq_pkg::CFG_LONG_PRESS, 16'd25);
        turn(138, 1'b0, 1'b1);
        add_gestures(110);
        wait_drain();
        add_gestures(110);
        wait_drain();

        // Random thresholds, debounce sometimes above the long-press time.
        write_cfg(rebq_pkg::CFG_DEBOUNCE,
                  rebq_pkg::CfgDataBits'($urandom_range(0, 300)));
        write_cfg(rebq_pkg::CFG_LONG_PRESS,
                  rebq_pkg::CfgDataBits'($urandom_range(0, 300)));
        add_gestures(180);
        wait_drain();

        repeat (8) @(posedge clk);
        $display("Run covered %0d samples and %0d checked status beats over six settings",
                 gen_count, beats_checked);
        $display("Reads returned %0d clicks, %0d long presses and %0d clamped deltas",
                 clicks_read, longs_read, clamped_reads);
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== rotary_encoder_button_qualifier_core.f =====
rtl/rebq_pkg.sv
rtl/rebq_in_if.sv
rtl/rebq_out_if.sv
rtl/rotary_encoder_button_qualifier_core.sv
tb/tb_rotary_encoder_button_qualifier_core.sv
